FILE: rtl/oaht_pkg.sv
package oaht_pkg;

  localparam int KEY_W  = 16;
  localparam int TAG_W  = 32;
  localparam int REC_W  = 16;
  localparam int SIZE_W = 11;
  localparam int S_W    = 12;
  localparam int SLOT_W = 10;
  localparam int COLL_W = 16;
  localparam int CNT_W  = 11;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
  localparam logic [COLL_W-1:0] COLL_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  localparam logic REG_TABLE_SIZE   = 1'b0;
  localparam logic REG_PROBE_METHOD = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SEARCH,
    OP_DELETE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [REC_W-1:0] rec;
  } item_t;

  function automatic op_t classify(input logic [1:0] mode);
    op_t op;
    case (mode)
      MODE_INSERT: op = OP_INSERT;
      MODE_SEARCH: op = OP_SEARCH;
      MODE_DELETE: op = OP_DELETE;
      default:     op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

FILE: rtl/oaht_front.sv
module oaht_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [15:0]            in_key_sum,
  input  logic [31:0]            in_name_tag,
  input  logic [15:0]            in_record_handle,
  input  logic                   clearing,
  output logic                   q_valid,
  output oaht_pkg::item_t        q_item,
  input  logic                   q_pop
);
  import oaht_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // hold off items while the store is being cleared or the queue is full
  assign in_ready = !clearing && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // classify and store the item
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: classify(in_mode), key: in_key_sum,
                         tag: in_name_tag, rec: in_record_handle};
    end
  end

endmodule

FILE: rtl/oaht_mod.sv
module oaht_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [oaht_pkg::KEY_W-1:0] dividend,
  input  logic [oaht_pkg::S_W-1:0]   divisor,
  output logic                       busy,
  output logic [oaht_pkg::S_W-1:0]   rem
);
  import oaht_pkg::*;

  localparam int CW = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] dvd_r, dvd_nxt;
  logic [S_W-1:0]   div_r;
  logic [S_W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [S_W:0]     trial;

  assign busy = busy_r;
  assign rem  = rem_r;

  // one restoring remainder step per cycle, key bits high to low
  always_comb begin
    trial    = {rem_r, dvd_r[KEY_W-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      rem_nxt  = (trial >= {1'b0, div_r}) ? S_W'(trial - {1'b0, div_r}) : S_W'(trial);
      dvd_nxt  = {dvd_r[KEY_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(KEY_W);
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

FILE: rtl/oaht_back.sv
module oaht_back #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [oaht_pkg::SIZE_W-1:0] table_size,
  input  logic                        probe_method,
  input  logic                        q_valid,
  input  oaht_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [oaht_pkg::SLOT_W-1:0] out_slot_index,
  output logic [oaht_pkg::REC_W-1:0]  out_found_record,
  output logic [oaht_pkg::COLL_W-1:0] out_collision_total,
  output logic [oaht_pkg::CNT_W-1:0]  out_entry_count
);
  import oaht_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CAP_LIM = (CAPACITY > 2047) ? 2047 : CAPACITY;
  localparam int MW      = 1 + TAG_W + REC_W;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_HASH  = 5'b00100,
    B_READ  = 5'b01000,
    B_CHECK = 5'b10000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t            item_r;
  logic [S_W-1:0]   s_cur, s_r;
  logic             lin_r;
  logic [S_W-1:0]   home_r, home_nxt, step_r, step_nxt;
  logic [S_W-1:0]   idx_r, idx_nxt, k_r, k_nxt;
  logic [COLL_W-1:0] coll_r, coll_nxt;
  logic [CNT_W-1:0] ec_r, ec_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [REC_W-1:0] out_rec_r, out_rec_nxt;
  logic             h_busy, s_busy;
  logic [S_W-1:0]   h_rem, s_rem;
  logic [S_W:0]     sum;
  logic [S_W-1:0]   idx_adv;
  logic [15:0]      load_lhs, load_rhs;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [MW-1:0]    wdata;
  logic [MW-1:0]    mem [CAPACITY];
  logic [MW-1:0]    rd_r;
  logic             rd_valid;
  logic [TAG_W-1:0] rd_tag;
  logic [REC_W-1:0] rd_rec;

  // limit the configured size to the usable range
  always_comb begin
    if (table_size < SIZE_MIN) begin
      s_cur = S_W'(SIZE_MIN);
    end else if (32'(table_size) > CAP_LIM) begin
      s_cur = S_W'(CAP_LIM);
    end else begin
      s_cur = S_W'(table_size);
    end
  end

  assign q_pop = (state_r == B_IDLE) && q_valid && !out_valid_r;

  // home slot and double-hashing step
  oaht_mod u_mod_home (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_pop),
    .dividend (q_item.key),
    .divisor  (s_cur),
    .busy     (h_busy),
    .rem      (h_rem)
  );

  oaht_mod u_mod_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_pop),
    .dividend (q_item.key),
    .divisor  (s_cur - S_W'(1)),
    .busy     (s_busy),
    .rem      (s_rem)
  );

  assign rd_valid = rd_r[MW-1];
  assign rd_tag   = rd_r[MW-2:REC_W];
  assign rd_rec   = rd_r[REC_W-1:0];
  assign sum      = {1'b0, idx_r} + {1'b0, step_r};
  assign idx_adv  = (sum >= {1'b0, s_r}) ? S_W'(sum - {1'b0, s_r}) : S_W'(sum);
  assign load_lhs = 16'(ec_r) * 16'd10;
  assign load_rhs = 16'(s_r) * 16'd7;

  assign clearing            = (state_r == B_CLEAR);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_slot_index      = out_slot_r;
  assign out_found_record    = out_rec_r;
  assign out_collision_total = coll_r;
  assign out_entry_count     = ec_r;

  // sequence the probe walk
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    home_nxt       = home_r;
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    coll_nxt       = coll_r;
    ec_nxt         = ec_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_rec_nxt    = out_rec_r;
    we             = 1'b0;
    waddr          = IDX_W'(idx_r);
    wdata          = {1'b0, item_r.tag, item_r.rec};
    case (state_r)
      B_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(CAPACITY - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (q_pop) begin
          if (q_item.op == OP_NONE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_slot_nxt   = '0;
            out_rec_nxt    = '0;
          end else begin
            state_nxt = B_HASH;
          end
        end
      end
      B_HASH: begin
        if (!h_busy && !s_busy) begin
          home_nxt = h_rem;
          step_nxt = lin_r ? S_W'(1) : s_rem + S_W'(1);
          idx_nxt  = h_rem;
          k_nxt    = '0;
          if (item_r.op == OP_INSERT && load_lhs > load_rhs) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_slot_nxt   = '0;
            out_rec_nxt    = '0;
            state_nxt      = B_IDLE;
          end else begin
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        out_rec_nxt  = '0;
        out_slot_nxt = '0;
        if (item_r.op == OP_INSERT) begin
          if (!rd_valid) begin
            we             = 1'b1;
            wdata          = {1'b1, item_r.tag, item_r.rec};
            ec_nxt         = (ec_r == CNT_MAX) ? ec_r : ec_r + CNT_W'(1);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_slot_nxt   = SLOT_W'(idx_r);
            state_nxt      = B_IDLE;
          end else begin
            coll_nxt = (coll_r == COLL_MAX) ? coll_r : coll_r + COLL_W'(1);
            if (k_r + S_W'(1) == s_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              state_nxt      = B_IDLE;
            end else begin
              idx_nxt   = idx_adv;
              k_nxt     = k_r + S_W'(1);
              state_nxt = B_READ;
            end
          end
        end else begin
          if (k_r != '0 && idx_r == home_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            state_nxt      = B_IDLE;
          end else if (rd_valid && rd_tag == item_r.tag) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_slot_nxt   = SLOT_W'(idx_r);
            state_nxt      = B_IDLE;
            if (item_r.op == OP_SEARCH) begin
              out_rec_nxt = rd_rec;
            end else begin
              we    = 1'b1;
              wdata = {1'b0, rd_tag, rd_rec};
            end
          end else if (k_r + S_W'(1) == s_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            state_nxt      = B_IDLE;
          end else begin
            idx_nxt   = idx_adv;
            k_nxt     = k_r + S_W'(1);
            state_nxt = B_READ;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      coll_r      <= '0;
      ec_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      coll_r      <= coll_nxt;
      ec_r        <= ec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the item, its size and the probe position
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      s_r    <= s_cur;
      lin_r  <= probe_method;
    end
    home_r       <= home_nxt;
    step_r       <= step_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_rec_r    <= out_rec_nxt;
  end

  // slot store: one write port, registered read at the probe slot
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[IDX_W'(idx_r)];
  end

endmodule

FILE: rtl/open_addressing_hash_table.sv
// Open-addressing hash table with insert, search and delete items.
// Input channel in_*: mode, key_sum, name_tag, record_handle with valid/ready.
// Result channel out_*: one result item per input item, in order, valid/ready.
// Configuration: APB port, table_size at 0x0, probe_method at 0x4; pready is
// always high and reads return the register value.
// An item queues in a two-entry front queue, then the back end reduces the key
// modulo the size and size-1 one bit per cycle, then walks the probe sequence
// with a READ and a CHECK state per slot (registered slot-store read). Mode 3
// is answered from the idle state with a miss and no probe walk.
// One item is processed at a time; the queue keeps accepting while a result
// waits. A stalled receiver holds the result and stops the back end, and the
// front accepts until its queue is full.
// After reset all CAPACITY slots are cleared, one slot a cycle; in_ready
// stays low during that pass. Configuration may be written meanwhile.
module open_addressing_hash_table #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_key_sum,
  input  logic [31:0] in_name_tag,
  input  logic [15:0] in_record_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_slot_index,
  output logic [15:0] out_found_record,
  output logic [15:0] out_collision_total,
  output logic [10:0] out_entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import oaht_pkg::*;

  logic [SIZE_W-1:0] tsize_r;
  logic              pmeth_r;
  logic              q_valid, q_pop, clearing;
  item_t             q_item;

  assign pready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= SIZE_RESET;
      pmeth_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TABLE_SIZE:   tsize_r <= pwdata[SIZE_W-1:0];
        REG_PROBE_METHOD: pmeth_r <= pwdata[0];
        default:          tsize_r <= tsize_r;
      endcase
    end
  end

  // read back configuration
  always_comb begin
    case (paddr[2])
      REG_TABLE_SIZE:   prdata = {21'd0, tsize_r};
      REG_PROBE_METHOD: prdata = {31'd0, pmeth_r};
      default:          prdata = '0;
    endcase
  end

  oaht_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_key_sum       (in_key_sum),
    .in_name_tag      (in_name_tag),
    .in_record_handle (in_record_handle),
    .clearing         (clearing),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  oaht_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .table_size          (tsize_r),
    .probe_method        (pmeth_r),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .clearing            (clearing),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_found_record    (out_found_record),
    .out_collision_total (out_collision_total),
    .out_entry_count     (out_entry_count)
  );

endmodule

FILE: verif/open_addressing_hash_table_tb.sv
`timescale 1ns / 100ps

module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [15:0] rec;
    logic [15:0] coll;
    logic [10:0] cnt;
  } result_t;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] key;
    logic [31:0] tag;
    logic [15:0] rec;
    bit          typed;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [15:0] in_key_sum = '0;
  logic [31:0] in_name_tag = '0;
  logic [15:0] in_record_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_slot_index;
  logic [15:0] out_found_record;
  logic [15:0] out_collision_total;
  logic [10:0] out_entry_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Table shadow and configuration copy
  bit          occupied [SLOTS];
  logic [31:0] tag_mem [SLOTS];
  logic [15:0] rec_mem [SLOTS];
  int          coll_total;
  int          n_entries;
  int          cfg_size;
  int          cfg_method;

  result_t     pending_results [$];
  logic [15:0] live_keys [$];
  logic [31:0] live_tags [$];
  row_t        directed [15];
  int          n_bad;
  int          n_received;
  int          idle_cycles;
  bit          no_idle;

  open_addressing_hash_table i_dut (.*);

  always #5 clk = ~clk;

  // Compute the result of one operation and update the shadow table
  function automatic result_t table_op(logic [1:0] mode, logic [15:0] key,
                                       logic [31:0] tag, logic [15:0] rec);
    result_t r;
    int s, home, step, idx, k, hit;
    bit placed;
    r = '{ST_MISS, '0, '0, '0, '0};
    s = cfg_size < 2 ? 2 : (cfg_size > SLOTS ? SLOTS : cfg_size);
    home = key % s;
    step = cfg_method ? 1 : 1 + key % (s - 1);
    idx = home;
    case (mode)
      MODE_INSERT: begin
        if (10 * n_entries > 7 * s) begin
          r.status = ST_FULL;
        end else begin
          placed = 1'b0;
          for (k = 0; k < s; k++) begin
            if (!occupied[idx]) begin
              occupied[idx] = 1'b1;
              tag_mem[idx] = tag;
              rec_mem[idx] = rec;
              if (n_entries < 2047) n_entries++;
              r.status = ST_OK;
              r.slot = 10'(idx);
              placed = 1'b1;
              break;
            end
            if (coll_total < 65535) coll_total++;
            idx += step;
            if (idx >= s) idx -= s;
          end
          if (!placed) r.status = ST_FULL;
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        hit = -1;
        for (k = 0; k < s; k++) begin
          if (k != 0 && idx == home) break;
          if (occupied[idx] && tag_mem[idx] == tag) begin
            hit = idx;
            break;
          end
          idx += step;
          if (idx >= s) idx -= s;
        end
        if (hit >= 0) begin
          r.status = ST_OK;
          r.slot = 10'(hit);
          if (mode == MODE_SEARCH) r.rec = rec_mem[hit];
          else occupied[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    r.coll = 16'(coll_total);
    r.cnt = 11'(n_entries);
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result
  task automatic send_item(logic [1:0] mode, logic [15:0] key, logic [31:0] tag,
                           logic [15:0] rec, bit typed, result_t typed_res);
    result_t r;
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_mode = mode;
    in_key_sum = key;
    in_name_tag = tag;
    in_record_handle = rec;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    r = table_op(mode, key, tag, rec);
    pending_results.push_back(typed ? typed_res : r);
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random(int n);
    result_t none;
    int pick, i;
    logic [1:0] mode;
    logic [15:0] key;
    logic [31:0] tag;
    none = '{ST_MISS, '0, '0, '0, '0};
    for (i = 0; i < n; i++) begin
      key = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 63)) : 16'($urandom);
      tag = $urandom;
      mode = MODE_INSERT;
      // mostly inserts, then searches and deletes of live names; some noise
      if ($urandom_range(0, 9) < 3) begin
        mode = 2'($urandom_range(0, 3));
      end else if (live_keys.size() > 0 && $urandom_range(0, 1)) begin
        pick = $urandom_range(0, live_keys.size() - 1);
        key = live_keys[pick];
        tag = live_tags[pick];
        mode = $urandom_range(0, 2) ? MODE_SEARCH : MODE_DELETE;
        if (mode == MODE_DELETE) begin
          live_keys.delete(pick);
          live_tags.delete(pick);
        end
      end else begin
        live_keys.push_back(key);
        live_tags.push_back(tag);
      end
      send_item(mode, key, tag, 16'($urandom), 1'b0, none);
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drain, settle, then reprogram size and probe method
  task automatic configure(int size, int method);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(negedge clk);
    write_reg({REG_TABLE_SIZE, 2'b00}, 32'(size));
    write_reg({REG_PROBE_METHOD, 2'b00}, 32'(method));
    cfg_size = size & 11'h7FF;
    cfg_method = method & 1;
    live_keys.delete();
    live_tags.delete();
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: random ready gaps and one long hold-off
  initial begin
    int w;
    wait (rst_n);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 14);
      if (n_received == 150) w = LONG_HOLD;
      @(negedge clk);
      out_ready = 1'b0;
      repeat (w) @(negedge clk);
      out_ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_received++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        n_bad++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          n_bad++;
        end
        if (out_slot_index !== e.slot) begin
          $error("slot_index: expected %0d, actual %0d", e.slot, out_slot_index);
          n_bad++;
        end
        if (out_found_record !== e.rec) begin
          $error("found_record: expected %0h, actual %0h", e.rec, out_found_record);
          n_bad++;
        end
        if (out_collision_total !== e.coll) begin
          $error("collision_total: expected %0d, actual %0d", e.coll, out_collision_total);
          n_bad++;
        end
        if (out_entry_count !== e.cnt) begin
          $error("entry_count: expected %0d, actual %0d", e.cnt, out_entry_count);
          n_bad++;
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    result_t none;
    int i;
    none = '{ST_MISS, '0, '0, '0, '0};
    n_bad = 0;
    n_received = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    coll_total = 0;
    n_entries = 0;
    cfg_size = 1021;
    cfg_method = 0;
    foreach (occupied[j]) begin
      occupied[j] = 1'b0;
      tag_mem[j] = '0;
      rec_mem[j] = '0;
    end

    // Directed items at reset configuration
    directed[0]  = '{MODE_INSERT, 16'd0, 32'd0, 16'd0, 1'b1,
                     '{ST_OK, 10'd0, 16'd0, 16'd0, 11'd1}};
    directed[1]  = '{MODE_SEARCH, 16'd0, 32'd0, 16'd0, 1'b1,
                     '{ST_OK, 10'd0, 16'd0, 16'd0, 11'd1}};
    directed[2]  = '{MODE_INSERT, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
                     '{ST_OK, 10'd191, 16'd0, 16'd0, 11'd2}};
    directed[3]  = '{MODE_SEARCH, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 1'b1,
                     '{ST_OK, 10'd191, 16'hFFFF, 16'd0, 11'd2}};
    directed[4]  = '{MODE_DELETE, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 1'b1,
                     '{ST_OK, 10'd191, 16'd0, 16'd0, 11'd2}};
    directed[5]  = '{MODE_SEARCH, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 1'b1,
                     '{ST_MISS, 10'd0, 16'd0, 16'd0, 11'd2}};
    directed[6]  = '{MODE_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
                     '{ST_MISS, 10'd0, 16'd0, 16'd0, 11'd2}};
    directed[7]  = '{MODE_DELETE, 16'd0, 32'd1, 16'd0, 1'b1,
                     '{ST_MISS, 10'd0, 16'd0, 16'd0, 11'd2}};
    directed[8]  = '{MODE_INSERT, 16'd1021, 32'd5, 16'd7, 1'b0, none};
    directed[9]  = '{MODE_INSERT, 16'd1021, 32'd5, 16'd9, 1'b0, none};
    directed[10] = '{MODE_SEARCH, 16'd1021, 32'd5, 16'd0, 1'b0, none};
    directed[11] = '{MODE_INSERT, 16'd2042, 32'd6, 16'h8001, 1'b0, none};
    directed[12] = '{MODE_SEARCH, 16'd0, 32'd5, 16'd0, 1'b0, none};
    directed[13] = '{MODE_DELETE, 16'd1021, 32'd5, 16'd0, 1'b0, none};
    directed[14] = '{MODE_SEARCH, 16'd1021, 32'd5, 16'd0, 1'b0, none};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < 15; i++) begin
      send_item(directed[i].mode, directed[i].key, directed[i].tag, directed[i].rec,
                directed[i].typed, directed[i].res);
    end

    configure(13, 1);
    send_random(60);
    configure(2, 0);
    send_random(30);
    configure(0, 1);
    send_random(20);
    configure(7, 0);
    send_random(40);
    configure(31, 0);
    send_random(40);
    configure(2047, 1);
    send_random(80);

    // Non-prime size: key 511 probes two slots only, so a third insert
    // finds no free slot; repeat it to drive the collision count to its limit
    configure(1024, 0);
    send_item(MODE_INSERT, 16'd511, 32'hA5A5_0001, 16'd1, 1'b0, none);
    send_item(MODE_INSERT, 16'd511, 32'hA5A5_0002, 16'd2, 1'b0, none);
    for (i = 0; i < 66; i++) begin
      send_item(MODE_INSERT, 16'd511, $urandom, 16'($urandom), 1'b0, none);
    end
    send_random(60);

    configure(1021, 1);
    send_random(160);
    configure(1021, 0);
    send_random(180);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/oaht_pkg.sv
rtl/oaht_front.sv
rtl/oaht_mod.sv
rtl/oaht_back.sv
rtl/open_addressing_hash_table.sv
verif/open_addressing_hash_table_tb.sv
